@@ hw/rtl/ced_pkg.sv @@
// Shared types, coefficient tables and codes of the edge detector.
package ced_pkg;

  localparam int TabSize   = 7;
  localparam int TabRadius = 3;

  // Gaussian-derivative kernels, signed Q3.12, offsets -3..3
  localparam logic signed [15:0] KX_TAB [TabSize][TabSize] = '{
    '{16'sd0, 16'sd0,   16'sd0,    16'sd0, 16'sd0,     16'sd0,    16'sd0},
    '{16'sd0, 16'sd5,   16'sd55,   16'sd0, -16'sd55,   -16'sd5,   16'sd0},
    '{16'sd1, 16'sd110, 16'sd1109, 16'sd0, -16'sd1109, -16'sd110, -16'sd1},
    '{16'sd3, 16'sd300, 16'sd3014, 16'sd0, -16'sd3014, -16'sd300, -16'sd3},
    '{16'sd1, 16'sd110, 16'sd1109, 16'sd0, -16'sd1109, -16'sd110, -16'sd1},
    '{16'sd0, 16'sd5,   16'sd55,   16'sd0, -16'sd55,   -16'sd5,   16'sd0},
    '{16'sd0, 16'sd0,   16'sd0,    16'sd0, 16'sd0,     16'sd0,    16'sd0}
  };

  localparam logic signed [15:0] KY_TAB [TabSize][TabSize] = '{
    '{16'sd0, 16'sd0,    16'sd1,     16'sd3,     16'sd1,     16'sd0,    16'sd0},
    '{16'sd0, 16'sd5,    16'sd110,   16'sd300,   16'sd110,   16'sd5,    16'sd0},
    '{16'sd0, 16'sd55,   16'sd1109,  16'sd3014,  16'sd1109,  16'sd55,   16'sd0},
    '{16'sd0, 16'sd0,    16'sd0,     16'sd0,     16'sd0,     16'sd0,    16'sd0},
    '{16'sd0, -16'sd55,  -16'sd1109, -16'sd3014, -16'sd1109, -16'sd55,  16'sd0},
    '{16'sd0, -16'sd5,   -16'sd110,  -16'sd300,  -16'sd110,  -16'sd5,   16'sd0},
    '{16'sd0, 16'sd0,    -16'sd1,    -16'sd3,    -16'sd1,    16'sd0,    16'sd0}
  };

  localparam logic [1:0] FuncWrite = 2'd0;
  localparam logic [1:0] FuncRun   = 2'd1;
  localparam logic [1:0] FuncRead  = 2'd2;

  localparam logic [2:0] CfgImageWidth  = 3'd0;
  localparam logic [2:0] CfgImageHeight = 3'd1;
  localparam logic [2:0] CfgLowThresh   = 3'd2;
  localparam logic [2:0] CfgLinkThresh  = 3'd3;
  localparam logic [2:0] CfgStrongThresh = 3'd4;

  localparam logic [1:0] DirZero = 2'b00;
  localparam logic [1:0] DirPos  = 2'b01;
  localparam logic [1:0] DirNeg  = 2'b11;

  typedef enum logic [23:0] {
    ST_IDLE  = 24'h000001,
    ST_CONV  = 24'h000002,
    ST_RESC  = 24'h000004,
    ST_SQX   = 24'h000008,
    ST_SQY   = 24'h000010,
    ST_SUM   = 24'h000020,
    ST_ROOT  = 24'h000040,
    ST_CLS1  = 24'h000080,
    ST_CLS2  = 24'h000100,
    ST_CLS3  = 24'h000200,
    ST_CLS4  = 24'h000400,
    ST_WRC   = 24'h000800,
    ST_NRD   = 24'h001000,
    ST_NCAP  = 24'h002000,
    ST_NB1   = 24'h004000,
    ST_NB1C  = 24'h008000,
    ST_NB2C  = 24'h010000,
    ST_NWR   = 24'h020000,
    ST_HRD   = 24'h040000,
    ST_HCAP  = 24'h080000,
    ST_HWALK = 24'h100000,
    ST_HCHK  = 24'h200000,
    ST_HSIDE = 24'h400000,
    ST_HNXT  = 24'h800000
  } state_t;

endpackage

@@ hw/rtl/ced_ram.sv @@
// Generic simple dual-port RAM with registered read.
module ced_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [Width-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/canny_edge_detector.sv @@
// Top level of the edge detector: command decode, run sequencer and result stores.
//
//   channel  direction  transfer at                 carries
//   in_*     in         start & !busy               func, row, col, pixel
//   out_*    out        out_valid (one cycle)       is_edge, magnitude, dir_x, dir_y
//   cfg_*    in         cfg_valid & cfg_ready       index, data
//
// Pixel writes and reads stream back to back while idle; a read result appears
// in the cycle after its transfer. A run keeps busy high through convolution,
// root and direction of every output pixel (OW x OH the output frame; one shared
// multiplier, one pixel read port), then suppression of every output pixel and
// hysteresis of every interior pixel with its walk steps.
// cfg_ready is low while busy. Reset is synchronous and restores the register
// defaults; the result side cannot stall.
module canny_edge_detector #(
  parameter int MAX_WIDTH     = 128,
  parameter int MAX_HEIGHT    = 128,
  parameter int FILTER_RADIUS = 2,
  parameter int KERNEL_SIZE   = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_func,
  input  logic [6:0]        in_row,
  input  logic [6:0]        in_col,
  input  logic [7:0]        in_pixel,
  output logic              out_valid,
  output logic              out_is_edge,
  output logic [15:0]       out_magnitude,
  output logic signed [1:0] out_dir_x,
  output logic signed [1:0] out_dir_y,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  import ced_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int AW    = RW + CW;
  localparam int Depth = 1 << AW;
  localparam int MaxD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DB    = $clog2(MaxD + 1);
  localparam int DW    = (DB > 8) ? DB : 8;
  localparam int SW    = DW + 1;
  localparam int KW    = $clog2(KERNEL_SIZE);
  localparam int AccW  = 24;

  state_t state_r;

  logic [7:0]  img_w_r, img_h_r;
  logic [15:0] low_r, link_r, strong_r;
  logic [DW-1:0] iw_r, ih_r, run_w_r, run_h_r;
  logic [DW-1:0] iw_c, ih_c, rw_c, rh_c;
  logic [DW-1:0] j_r, i_r;
  logic [KW-1:0] ky_r, kx_r;
  logic [1:0]    ph_r;
  logic [7:0]    pix_r;
  logic signed [AccW-1:0] acc_x_r, acc_y_r;
  logic signed [33:0] prod_r, rhs_r;
  logic signed [15:0] gx_r, gy_r;
  logic [31:0] rem_r, res_r, bit_r;
  logic [31:0] rem_new, res_new;
  logic [32:0] trial;
  logic [3:0]  it_r;
  logic [15:0] mag_r, mc_r;
  logic [1:0]  dx_r, dy_r;
  logic [3:0]  nd_r;
  logic        zero_r, side_r;
  logic signed [1:0] sr_r, sc_r;
  logic signed [SW-1:0] pr_r, pc_r, js, is;
  logic        rd_pend_r, rd_in_r;

  logic signed [4:0] tr_s, tc_s;
  logic [DW-1:0] tap_pr, tap_pc;
  logic          tap_ok;
  logic signed [15:0] coef_x, coef_y;
  logic [7:0]    pix_use;
  logic signed [16:0] mul_a, mul_b;
  logic signed [33:0] mul_p;
  logic [DW-1:0] dxe, dye;
  logic          walk_in, link_hit, accept;

  logic [AW-1:0] in_addr, ctr_addr;
  logic          pix_we;
  logic [AW-1:0] pix_raddr, mag_raddr, dir_raddr, supp_raddr, edge_waddr;
  logic [7:0]    pix_rd;
  logic [15:0]   mag_rd, supp_rd;
  logic [3:0]    dir_rd;
  logic          edge_rd, mag_we, supp_we, edge_we, edge_wdata;

  function automatic logic signed [15:0] rescale(input logic signed [AccW-1:0] s);
    logic [AccW-1:0] a;
    logic [AccW-1:0] q;
    a = s[AccW-1] ? AccW'(-s) : AccW'(s);
    q = (a + AccW'(2048)) >> 12;
    if (s[AccW-1]) begin
      rescale = (q > AccW'(32768)) ? 16'sh8000 : $signed(16'(AccW'(0) - q));
    end else begin
      rescale = (q > AccW'(32767)) ? 16'sh7fff : $signed(16'(q));
    end
  endfunction

  function automatic logic [1:0] classify(input logic signed [33:0] lhs,
                                          input logic signed [33:0] rhs);
    if (lhs > rhs) begin
      classify = DirPos;
    end else if (lhs < -rhs) begin
      classify = DirNeg;
    end else begin
      classify = DirZero;
    end
  endfunction

  assign busy      = (state_r != ST_IDLE);
  // hold configuration off while a run is in progress
  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  // clamp the configured size and derive the output frame
  always_comb begin
    iw_c = (DW'(img_w_r) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(img_w_r);
    ih_c = (DW'(img_h_r) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(img_h_r);
    rw_c = (iw_c > DW'(2 * FILTER_RADIUS)) ? iw_c - DW'(2 * FILTER_RADIUS) : '0;
    rh_c = (ih_c > DW'(2 * FILTER_RADIUS)) ? ih_c - DW'(2 * FILTER_RADIUS) : '0;
  end

  // kernel tap under the sequencer
  always_comb begin
    tr_s   = $signed({2'b00, 3'(ky_r)}) + $signed(5'(TabRadius - FILTER_RADIUS));
    tc_s   = $signed({2'b00, 3'(kx_r)}) + $signed(5'(TabRadius - FILTER_RADIUS));
    tap_pr = j_r + DW'(ky_r);
    tap_pc = i_r + DW'(kx_r);
    tap_ok = (tr_s >= 0) && (tr_s < 5'(TabSize)) && (tc_s >= 0) && (tc_s < 5'(TabSize))
             && (tap_pr < ih_r) && (tap_pc < iw_r);
    coef_x = tap_ok ? KX_TAB[tr_s[2:0]][tc_s[2:0]] : '0;
    coef_y = tap_ok ? KY_TAB[tr_s[2:0]][tc_s[2:0]] : '0;
    pix_use = tap_ok ? pix_rd : '0;
  end

  // shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_CONV: begin
        if (ph_r == 2'd2) begin
          mul_a = 17'(coef_y);
          mul_b = $signed({9'b0, pix_r});
        end else begin
          mul_a = 17'(coef_x);
          mul_b = $signed({9'b0, pix_use});
        end
      end
      ST_SQX: begin
        mul_a = 17'(gx_r);
        mul_b = 17'(gx_r);
      end
      ST_SQY: begin
        mul_a = 17'(gy_r);
        mul_b = 17'(gy_r);
      end
      ST_CLS1: begin
        mul_a = $signed({1'b0, mag_r});
        mul_b = 17'sd3827;
      end
      ST_CLS2: begin
        mul_a = 17'(gx_r);
        mul_b = 17'sd10000;
      end
      ST_CLS3: begin
        mul_a = 17'(gy_r);
        mul_b = 17'sd10000;
      end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // one restoring step of the integer root
  always_comb begin
    trial = {1'b0, res_r} + {1'b0, bit_r};
    if ({1'b0, rem_r} >= trial) begin
      rem_new = rem_r - trial[31:0];
      res_new = (res_r >> 1) + bit_r;
    end else begin
      rem_new = rem_r;
      res_new = res_r >> 1;
    end
  end

  always_comb begin
    dxe      = {{(DW-2){nd_r[1]}}, nd_r[1:0]};
    dye      = {{(DW-2){nd_r[3]}}, nd_r[3:2]};
    js       = $signed({1'b0, j_r});
    is       = $signed({1'b0, i_r});
    walk_in  = (pc_r > 0) && (pc_r < $signed({1'b0, run_w_r}))
               && (pr_r > 0) && (pr_r < $signed({1'b0, run_h_r}));
    link_hit = (supp_rd > link_r) && (supp_rd < strong_r);
    in_addr  = {RW'(in_row), CW'(in_col)};
    ctr_addr = {RW'(j_r), CW'(i_r)};
    pix_we   = accept && (in_func == FuncWrite) && (int'(in_row) < MAX_HEIGHT)
               && (int'(in_col) < MAX_WIDTH);
    pix_raddr = {RW'(tap_pr), CW'(tap_pc)};
  end

  // store port selection
  always_comb begin
    mag_raddr  = ctr_addr;
    dir_raddr  = ctr_addr;
    supp_raddr = ctr_addr;
    edge_waddr = ctr_addr;
    mag_we     = 1'b0;
    supp_we    = 1'b0;
    edge_we    = 1'b0;
    edge_wdata = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        dir_raddr  = in_addr;
        supp_raddr = in_addr;
      end
      ST_WRC: mag_we = 1'b1;
      ST_NB1: mag_raddr = {RW'(j_r + dye), CW'(i_r + dxe)};
      ST_NB1C: mag_raddr = {RW'(j_r - dye), CW'(i_r - dxe)};
      ST_NWR: begin
        supp_we = 1'b1;
        edge_we = 1'b1;
      end
      ST_HCAP: begin
        edge_we    = (supp_rd > strong_r);
        edge_wdata = 1'b1;
      end
      ST_HWALK: supp_raddr = {RW'(pr_r), CW'(pc_r)};
      ST_HCHK: begin
        edge_waddr = {RW'(pr_r), CW'(pc_r)};
        edge_we    = link_hit;
        edge_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  ced_ram #(.Width(8), .Depth(Depth)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(in_addr), .wdata(in_pixel),
    .raddr(pix_raddr), .rdata(pix_rd)
  );

  ced_ram #(.Width(16), .Depth(Depth)) u_mag_ram (
    .clk(clk), .we(mag_we), .waddr(ctr_addr), .wdata(mag_r),
    .raddr(mag_raddr), .rdata(mag_rd)
  );

  ced_ram #(.Width(4), .Depth(Depth)) u_dir_ram (
    .clk(clk), .we(mag_we), .waddr(ctr_addr), .wdata({dy_r, dx_r}),
    .raddr(dir_raddr), .rdata(dir_rd)
  );

  ced_ram #(.Width(16), .Depth(Depth)) u_supp_ram (
    .clk(clk), .we(supp_we), .waddr(ctr_addr), .wdata(zero_r ? 16'd0 : mc_r),
    .raddr(supp_raddr), .rdata(supp_rd)
  );

  ced_ram #(.Width(1), .Depth(Depth)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
    .raddr(in_addr), .rdata(edge_rd)
  );

  assign out_valid     = rd_pend_r;
  assign out_is_edge   = rd_in_r & edge_rd;
  assign out_magnitude = rd_in_r ? supp_rd : 16'd0;
  assign out_dir_x     = rd_in_r ? $signed(dir_rd[1:0]) : 2'sd0;
  assign out_dir_y     = rd_in_r ? $signed(dir_rd[3:2]) : 2'sd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      img_w_r   <= 8'd128;
      img_h_r   <= 8'd128;
      low_r     <= 16'd100;
      link_r    <= 16'd200;
      strong_r  <= 16'd800;
      run_w_r   <= '0;
      run_h_r   <= '0;
      rd_pend_r <= 1'b0;
      rd_in_r   <= 1'b0;
    end else begin
      rd_pend_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CfgImageWidth:   img_w_r  <= cfg_data[7:0];
          CfgImageHeight:  img_h_r  <= cfg_data[7:0];
          CfgLowThresh:    low_r    <= cfg_data;
          CfgLinkThresh:   link_r   <= cfg_data;
          CfgStrongThresh: strong_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            unique case (in_func)
              FuncRead: begin
                rd_pend_r <= 1'b1;
                rd_in_r   <= (DW'(in_row) < run_h_r) && (DW'(in_col) < run_w_r);
              end
              FuncRun: begin
                iw_r    <= iw_c;
                ih_r    <= ih_c;
                run_w_r <= rw_c;
                run_h_r <= rh_c;
                j_r     <= '0;
                i_r     <= '0;
                ky_r    <= '0;
                kx_r    <= '0;
                ph_r    <= '0;
                acc_x_r <= '0;
                acc_y_r <= '0;
                if (rw_c != '0 && rh_c != '0) begin
                  state_r <= ST_CONV;
                end
              end
              default: ;
            endcase
          end
        end

        ST_CONV: begin
          ph_r <= ph_r + 2'd1;
          case (ph_r)
            2'd1: begin
              prod_r <= mul_p;
              pix_r  <= pix_use;
            end
            2'd2: begin
              acc_x_r <= acc_x_r + AccW'(prod_r);
              prod_r  <= mul_p;
            end
            2'd3: begin
              acc_y_r <= acc_y_r + AccW'(prod_r);
              if (kx_r == KW'(KERNEL_SIZE - 1)) begin
                kx_r <= '0;
                if (ky_r == KW'(KERNEL_SIZE - 1)) begin
                  state_r <= ST_RESC;
                end else begin
                  ky_r <= ky_r + KW'(1);
                end
              end else begin
                kx_r <= kx_r + KW'(1);
              end
            end
            default: ;
          endcase
        end

        ST_RESC: begin
          gx_r    <= rescale(acc_x_r);
          gy_r    <= rescale(acc_y_r);
          state_r <= ST_SQX;
        end

        ST_SQX: begin
          prod_r  <= mul_p;
          state_r <= ST_SQY;
        end

        ST_SQY: begin
          rem_r   <= prod_r[31:0];
          prod_r  <= mul_p;
          state_r <= ST_SUM;
        end

        ST_SUM: begin
          rem_r   <= rem_r + prod_r[31:0];
          res_r   <= '0;
          bit_r   <= 32'h4000_0000;
          it_r    <= '0;
          state_r <= ST_ROOT;
        end

        ST_ROOT: begin
          rem_r <= rem_new;
          res_r <= res_new;
          bit_r <= bit_r >> 2;
          it_r  <= it_r + 4'd1;
          if (it_r == 4'd15) begin
            if (res_new[15:0] > low_r) begin
              mag_r   <= res_new[15:0];
              state_r <= ST_CLS1;
            end else begin
              mag_r   <= '0;
              dx_r    <= DirZero;
              dy_r    <= DirZero;
              state_r <= ST_WRC;
            end
          end
        end

        ST_CLS1: begin
          prod_r  <= mul_p;
          state_r <= ST_CLS2;
        end

        ST_CLS2: begin
          rhs_r   <= prod_r;
          prod_r  <= mul_p;
          state_r <= ST_CLS3;
        end

        ST_CLS3: begin
          dx_r    <= classify(prod_r, rhs_r);
          prod_r  <= mul_p;
          state_r <= ST_CLS4;
        end

        ST_CLS4: begin
          dy_r    <= classify(prod_r, rhs_r);
          state_r <= ST_WRC;
        end

        ST_WRC: begin
          ky_r    <= '0;
          kx_r    <= '0;
          ph_r    <= '0;
          acc_x_r <= '0;
          acc_y_r <= '0;
          state_r <= ST_CONV;
          if (i_r == run_w_r - DW'(1)) begin
            i_r <= '0;
            if (j_r == run_h_r - DW'(1)) begin
              j_r     <= '0;
              state_r <= ST_NRD;
            end else begin
              j_r <= j_r + DW'(1);
            end
          end else begin
            i_r <= i_r + DW'(1);
          end
        end

        ST_NRD: state_r <= ST_NCAP;

        ST_NCAP: begin
          mc_r   <= mag_rd;
          nd_r   <= dir_rd;
          zero_r <= 1'b0;
          if ((j_r > '0) && (j_r < run_h_r - DW'(1)) && (i_r > '0)
              && (i_r < run_w_r - DW'(1)) && (dir_rd != 4'd0)) begin
            state_r <= ST_NB1;
          end else begin
            state_r <= ST_NWR;
          end
        end

        ST_NB1: state_r <= ST_NB1C;

        ST_NB1C: begin
          if (mc_r < mag_rd) begin
            zero_r <= 1'b1;
          end
          state_r <= ST_NB2C;
        end

        ST_NB2C: begin
          if (mc_r < mag_rd) begin
            zero_r <= 1'b1;
          end
          state_r <= ST_NWR;
        end

        ST_NWR: begin
          state_r <= ST_NRD;
          if (i_r == run_w_r - DW'(1)) begin
            i_r <= '0;
            if (j_r == run_h_r - DW'(1)) begin
              // hysteresis needs at least one interior pixel
              if (run_w_r >= DW'(3) && run_h_r >= DW'(3)) begin
                j_r     <= DW'(1);
                i_r     <= DW'(1);
                state_r <= ST_HRD;
              end else begin
                state_r <= ST_IDLE;
              end
            end else begin
              j_r <= j_r + DW'(1);
            end
          end else begin
            i_r <= i_r + DW'(1);
          end
        end

        ST_HRD: state_r <= ST_HCAP;

        ST_HCAP: begin
          state_r <= ST_HNXT;
          if (supp_rd > strong_r) begin
            sr_r   <= $signed(dir_rd[1:0]);
            sc_r   <= -$signed(dir_rd[3:2]);
            side_r <= 1'b0;
            pr_r   <= js + SW'($signed(dir_rd[1:0]));
            pc_r   <= is - SW'($signed(dir_rd[3:2]));
            if (dir_rd != 4'd0) begin
              state_r <= ST_HWALK;
            end
          end
        end

        ST_HWALK: begin
          state_r <= walk_in ? ST_HCHK : ST_HSIDE;
        end

        ST_HCHK: begin
          if (link_hit) begin
            pr_r    <= pr_r + SW'(sr_r);
            pc_r    <= pc_r + SW'(sc_r);
            state_r <= ST_HWALK;
          end else begin
            state_r <= ST_HSIDE;
          end
        end

        ST_HSIDE: begin
          // turn around once, then move on
          if (!side_r) begin
            side_r  <= 1'b1;
            sr_r    <= -sr_r;
            sc_r    <= -sc_r;
            pr_r    <= js - SW'(sr_r);
            pc_r    <= is - SW'(sc_r);
            state_r <= ST_HWALK;
          end else begin
            state_r <= ST_HNXT;
          end
        end

        ST_HNXT: begin
          state_r <= ST_HRD;
          if (i_r == run_w_r - DW'(2)) begin
            i_r <= DW'(1);
            if (j_r == run_h_r - DW'(2)) begin
              state_r <= ST_IDLE;
            end else begin
              j_r <= j_r + DW'(1);
            end
          end else begin
            i_r <= i_r + DW'(1);
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ dv/ced_checker.sv @@
// Checker for the edge detector: predicts read results and compares them.
`timescale 1ns / 1ps
module ced_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        in_func,
  input  logic [6:0]        in_row,
  input  logic [6:0]        in_col,
  input  logic [7:0]        in_pixel,
  input  logic              out_valid,
  input  logic              out_is_edge,
  input  logic [15:0]       out_magnitude,
  input  logic signed [1:0] out_dir_x,
  input  logic signed [1:0] out_dir_y,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  output int                errors,
  output int                pending,
  output int                reads_checked,
  output int                runs_seen
);

  import ced_pkg::*;

  localparam int MaxW = 128;
  localparam int MaxH = 128;
  localparam int Rad  = 2;
  localparam int Ksz  = 5;

  typedef struct packed {
    logic        is_edge;
    logic [15:0] magnitude;
    logic [1:0]  dir_x;
    logic [1:0]  dir_y;
  } pixel_result_t;

  logic [7:0]  img_mem  [MaxW*MaxH];
  logic [15:0] mag_mem  [MaxW*MaxH];
  logic [15:0] thin_mem [MaxW*MaxH];
  logic [1:0]  dx_mem   [MaxW*MaxH];
  logic [1:0]  dy_mem   [MaxW*MaxH];
  logic        edge_mem [MaxW*MaxH];

  int unsigned img_w, img_h, thr_low, thr_link, thr_strong;
  int          out_w, out_h;
  pixel_result_t expected_q[$];

  function automatic int idx(int r, int c);
    return r * MaxW + c;
  endfunction

  function automatic int dir_val(logic [1:0] code);
    return (code == DirNeg) ? -1 : ((code == DirPos) ? 1 : 0);
  endfunction

  function automatic logic signed [15:0] round_grad(longint s);
    longint a;
    longint q;
    a = (s < 0) ? -s : s;
    q = (a + 2048) >>> 12;
    if (s < 0) begin
      if (q > 32768) q = 32768;
      return 16'(-q);
    end
    if (q > 32767) q = 32767;
    return 16'(q);
  endfunction

  function automatic int unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return (res > 65535) ? 65535 : int'(res);
  endfunction

  function automatic logic [1:0] dir_class(int g, int unsigned m);
    longint lhs;
    longint rhs;
    lhs = longint'(g) * 10000;
    rhs = longint'(m) * 3827;
    if (lhs > rhs) return DirPos;
    if (lhs < -rhs) return DirNeg;
    return DirZero;
  endfunction

  task automatic trace_edge(int j, int i, int sr, int sc);
    int jj;
    int ii;
    int unsigned m;
    jj = j + sr;
    ii = i + sc;
    if (sr == 0 && sc == 0) return;
    while (ii > 0 && ii < out_w && jj > 0 && jj < out_h) begin
      m = thin_mem[idx(jj, ii)];
      if (!(thr_link < m && m < thr_strong)) break;
      edge_mem[idx(jj, ii)] = 1'b1;
      jj += sr;
      ii += sc;
    end
  endtask

  task automatic detect_edges();
    int iw, ih, tr, tc, pr, pc, dx, dy;
    longint sx, sy;
    logic signed [15:0] gx, gy;
    int unsigned m;
    iw = (img_w > MaxW) ? MaxW : img_w;
    ih = (img_h > MaxH) ? MaxH : img_h;
    out_w = (iw > 2*Rad) ? iw - 2*Rad : 0;
    out_h = (ih > 2*Rad) ? ih - 2*Rad : 0;
    for (int j = 0; j < out_h; j++)
      for (int i = 0; i < out_w; i++) begin
        sx = 0;
        sy = 0;
        for (int ky = 0; ky < Ksz; ky++)
          for (int kx = 0; kx < Ksz; kx++) begin
            tr = ky - Rad + TabRadius;
            tc = kx - Rad + TabRadius;
            pr = j + ky;
            pc = i + kx;
            if (pr < ih && pc < iw) begin
              sx += longint'(KX_TAB[tr][tc]) * img_mem[idx(pr, pc)];
              sy += longint'(KY_TAB[tr][tc]) * img_mem[idx(pr, pc)];
            end
          end
        gx = round_grad(sx);
        gy = round_grad(sy);
        m = int_root(longint'(gx) * gx + longint'(gy) * gy);
        dx_mem[idx(j, i)] = DirZero;
        dy_mem[idx(j, i)] = DirZero;
        if (m > thr_low) begin
          dx_mem[idx(j, i)] = dir_class(gx, m);
          dy_mem[idx(j, i)] = dir_class(gy, m);
        end else begin
          m = 0;
        end
        mag_mem[idx(j, i)] = 16'(m);
      end
    for (int j = 0; j < out_h; j++)
      for (int i = 0; i < out_w; i++) begin
        m = mag_mem[idx(j, i)];
        if (j > 0 && j < out_h - 1 && i > 0 && i < out_w - 1) begin
          dx = dir_val(dx_mem[idx(j, i)]);
          dy = dir_val(dy_mem[idx(j, i)]);
          if ((dx != 0 || dy != 0) && (m < mag_mem[idx(j + dy, i + dx)] ||
              m < mag_mem[idx(j - dy, i - dx)]))
            m = 0;
        end
        thin_mem[idx(j, i)] = 16'(m);
      end
    foreach (edge_mem[k]) edge_mem[k] = 1'b0;
    for (int j = 1; j < out_h - 1; j++)
      for (int i = 1; i < out_w - 1; i++)
        if (thin_mem[idx(j, i)] > thr_strong) begin
          dx = dir_val(dx_mem[idx(j, i)]);
          dy = dir_val(dy_mem[idx(j, i)]);
          edge_mem[idx(j, i)] = 1'b1;
          trace_edge(j, i, dx, -dy);
          trace_edge(j, i, -dx, dy);
        end
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    pixel_result_t exp_r;
    pixel_result_t got;
    if (!rst_n) begin
      img_w <= 128;
      img_h <= 128;
      thr_low <= 100;
      thr_link <= 200;
      thr_strong <= 800;
      out_w <= 0;
      out_h <= 0;
      expected_q.delete();
      errors <= 0;
      reads_checked <= 0;
      runs_seen <= 0;
    end else begin
      got = '{out_is_edge, out_magnitude, out_dir_x, out_dir_y};
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with nothing expected: %p", $time, got);
        end else begin
          exp_r = expected_q.pop_front();
          reads_checked++;
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch: expected %p, got %p", $time, exp_r, got);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CfgImageWidth:   img_w = cfg_data[7:0];
          CfgImageHeight:  img_h = cfg_data[7:0];
          CfgLowThresh:    thr_low = cfg_data;
          CfgLinkThresh:   thr_link = cfg_data;
          CfgStrongThresh: thr_strong = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        case (in_func)
          FuncWrite: img_mem[idx(in_row, in_col)] = in_pixel;
          FuncRun: begin
            detect_edges();
            runs_seen++;
          end
          FuncRead: begin
            exp_r = '0;
            if (in_row < out_h && in_col < out_w)
              exp_r = '{edge_mem[idx(in_row, in_col)], thin_mem[idx(in_row, in_col)],
                        dx_mem[idx(in_row, in_col)], dy_mem[idx(in_row, in_col)]};
            expected_q.push_back(exp_r);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ dv/tb_top.sv @@
// Testbench top for the edge detector: stimulus, configuration and verdict.
`timescale 1ns / 1ps
module tb_top;
  import ced_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_func;
  logic [6:0]        in_row;
  logic [6:0]        in_col;
  logic [7:0]        in_pixel;
  logic              out_valid;
  logic              out_is_edge;
  logic [15:0]       out_magnitude;
  logic signed [1:0] out_dir_x;
  logic signed [1:0] out_dir_y;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [15:0]       cfg_data;
  int                errors;
  int                pending;
  int                reads_checked;
  int                runs_seen;
  int                items_sent;
  int                phases_done;

  canny_edge_detector dut (.*);

  ced_checker u_checker (.*);

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic idle_gap();
    int n;
    n = $urandom_range(0, 99);
    if (n < 65) return;
    n = (n < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    start = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send(logic [1:0] f, logic [6:0] r, logic [6:0] c, logic [7:0] p);
    start = 1'b1;
    in_func = f;
    in_row = r;
    in_col = c;
    in_pixel = p;
    do @(posedge clk); while (busy);
    @(negedge clk);
    items_sent++;
    idle_gap();
  endtask

  task automatic drain();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] i, logic [15:0] d);
    cfg_valid = 1'b1;
    cfg_index = i;
    cfg_data = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    repeat ($urandom_range(0, 3)) @(negedge clk);
  endtask

  task automatic set_frame(int w, int h, int lo, int lk, int st);
    drain();
    write_reg(CfgImageWidth, 16'(w));
    write_reg(CfgImageHeight, 16'(h));
    write_reg(CfgLowThresh, 16'(lo));
    write_reg(CfgLinkThresh, 16'(lk));
    write_reg(CfgStrongThresh, 16'(st));
  endtask

  // Fill the image with a pattern likely to produce edges, then run and read back.
  task automatic frame_pass(int w, int h);
    int mode, k, lo_v, hi_v, v, ow, oh;
    mode = $urandom_range(0, 4);
    k = $urandom_range(1, 10);
    lo_v = $urandom_range(0, 60);
    hi_v = $urandom_range(180, 255);
    if (w > 128) w = 128;
    if (h > 128) h = 128;
    for (int r = 0; r < h; r++)
      for (int c = 0; c < w; c++) begin
        case (mode)
          0: v = $urandom_range(0, 255);
          1: v = (c < k) ? lo_v : hi_v;
          2: v = (r < k) ? lo_v : hi_v;
          3: v = (r + c < k + 3) ? lo_v : hi_v;
          default: v = (((r / 2) + (c / 3)) % 2) ? hi_v : lo_v;
        endcase
        if (mode != 0) v = v + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        send(FuncWrite, 7'(r), 7'(c), 8'(v));
      end
    send(FuncRun, 7'($urandom), 7'($urandom), 8'($urandom));
    ow = (w > 4) ? w - 4 : 0;
    oh = (h > 4) ? h - 4 : 0;
    for (int r = 0; r < oh; r++)
      for (int c = 0; c < ow; c++)
        if (ow * oh <= 64 || $urandom_range(0, 3) == 0) send(FuncRead, 7'(r), 7'(c), 8'($urandom));
    // probe outside the output frame and the unused code
    repeat (3) send(FuncRead, 7'($urandom_range(oh, 127)), 7'($urandom), 8'($urandom));
    send(2'd3, 7'($urandom), 7'($urandom), 8'($urandom));
    phases_done++;
  endtask

  initial begin
    int w, h, lo, lk, st;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FuncWrite;
    in_row = '0;
    in_col = '0;
    in_pixel = '0;
    cfg_valid = 1'b0;
    cfg_index = CfgImageWidth;
    cfg_data = '0;
    items_sent = 0;
    phases_done = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // before any run every read returns zeros
    send(FuncRead, 7'd0, 7'd0, 8'd0);
    send(FuncRead, 7'd127, 7'd127, 8'd255);
    send(2'd3, 7'd127, 7'd0, 8'd255);
    send(FuncWrite, 7'd127, 7'd127, 8'd255);
    send(FuncWrite, 7'd127, 7'd0, 8'd0);

    // size extremes: single output pixel, wide strip, saturated thresholds, tall strip
    set_frame(5, 5, 0, 0, 0);
    frame_pass(5, 5);
    set_frame(24, 5, 20, 40, 150);
    frame_pass(24, 5);
    set_frame(12, 6, 65535, 65535, 65535);
    frame_pass(12, 6);
    set_frame(5, 24, 0, 65535, 0);
    frame_pass(5, 24);

    while (items_sent < 650) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(5, 12);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 20) : $urandom_range(5, 12);
      lo = $urandom_range(0, 120);
      lk = $urandom_range(0, 250);
      st = $urandom_range(lk, 450);
      if ($urandom_range(0, 7) == 0) st = $urandom_range(0, 65535);
      set_frame(w, h, lo, lk, st);
      frame_pass(w, h);
      // hold off until all reads have returned, then read again, with random idle gaps between reads
      drain();
      repeat (4) send(FuncRead, 7'($urandom_range(0, h)), 7'($urandom_range(0, w)), 8'($urandom));
    end

    drain();
    repeat (20) @(negedge clk);
    $display("Covered %0d phases, %0d runs, %0d items sent, %0d reads checked.",
             phases_done, runs_seen, items_sent, reads_checked);
    if (errors == 0 && pending == 0) begin
      $display("canny_edge_detector test passed");
    end else begin
      $display("canny_edge_detector test failed");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("canny_edge_detector test failed");
    $finish;
  end

endmodule

@@ canny_edge_detector.f @@
hw/rtl/ced_pkg.sv
hw/rtl/ced_ram.sv
hw/rtl/canny_edge_detector.sv
dv/ced_checker.sv
dv/tb_top.sv
